@@ rtl/alru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alru_pkg
// Shared types, register indexes and defaults for the aging page replacer.
// ----------------------------------------------------------------------------
package alru_pkg;

	// Default sizing
	localparam int FRAMES_DEF     = 8;
	localparam int PAGE_COUNT_DEF = 256;
	localparam int AGE_WIDTH_DEF  = 8;

	// Configuration register indexes
	localparam logic [2:0] CFG_FRAMES_IN_USE   = 3'd0;
	localparam logic [2:0] CFG_SHIFT_PERIOD    = 3'd1;
	localparam logic [2:0] CFG_HIT_COST        = 3'd2;
	localparam logic [2:0] CFG_MISS_EXTRA_COST = 3'd3;
	localparam logic [2:0] CFG_AGE_BITS        = 3'd4;

	// Configuration reset values
	localparam logic [3:0]  FRAMES_IN_USE_RST   = 4'd4;
	localparam logic [15:0] SHIFT_PERIOD_RST    = 16'd9;
	localparam logic [7:0]  HIT_COST_RST        = 8'd1;
	localparam logic [7:0]  MISS_EXTRA_COST_RST = 8'd3;
	localparam logic [3:0]  AGE_BITS_RST        = 4'd5;

	typedef struct packed {
		logic [7:0] page_number;
		logic       run_end;
	} item_t;

	typedef struct packed {
		logic        page_fault;
		logic [2:0]  frame;
		logic        evicted;
		logic [7:0]  evicted_page;
		logic [31:0] fault_total;
		logic        last_result;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_EVICT
	} state_t;

endpackage

@@ rtl/alru_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alru_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module alru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/alru_victim.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alru_victim
// Picks the frame with the smallest age below the frame cap, lowest index on ties.
// ----------------------------------------------------------------------------
module alru_victim
	import alru_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
	input  logic [AGE_WIDTH-1:0]                        age [FRAMES],
	input  logic [$clog2(FRAMES + 1)-1:0]               cap,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] victim
);

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);

	logic [FRAMES-1:0] is_min;

	// pairwise compare: frame i is a minimum if no active frame is smaller
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			is_min[i] = (CW'(i) < cap);
			for (int j = 0; j < FRAMES; j++) begin
				if ((CW'(j) < cap) && (age[j] < age[i])) begin
					is_min[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		victim = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (is_min[i]) begin
				victim = FW'(i);
			end
		end
	end

endmodule

@@ rtl/aging_lru_page_replacement_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_lru_page_replacement_core
// Aging (approximate LRU) page replacement over a page map held in RAM.
// ----------------------------------------------------------------------------
//
// Channel   Signals                          Transfer when
// -------   ------------------------------   ---------------------------
// request   start, busy, item                start && !busy
// result    done, result                     done (one cycle, no stall)
// config    cfg_valid, cfg_ready,            cfg_valid && cfg_ready
//           cfg_index, cfg_data
//
// Steps: the look state takes the registered page-map RAM read; a hit ends
// there, while a miss goes on to the evict state, which takes the victim
// frame's old page from the frame map and invalidates it in the page map.
// Reset: after arst_n releases, busy stays high while the page map is swept
// to invalid. Config writes are taken at any time.
// Stalls: the receiver cannot stall; done is a single-cycle strobe and the
// next start can be taken in the same cycle that done is shown.
//
module aging_lru_page_replacement_core
	import alru_pkg::*;
#(
	parameter int FRAMES     = FRAMES_DEF,
	parameter int PAGE_COUNT = PAGE_COUNT_DEF,
	parameter int AGE_WIDTH  = AGE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;  // frame index
	localparam int CW = $clog2(FRAMES + 1);                 // frame count
	localparam int PW = $clog2(PAGE_COUNT);                 // page index

	// ------------------------------------------------------------------
	// Config registers
	// ------------------------------------------------------------------
	logic [3:0]  frames_in_use_q;
	logic [15:0] shift_period_q;
	logic [7:0]  hit_cost_q;
	logic [7:0]  miss_extra_cost_q;
	logic [3:0]  age_bits_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q   <= FRAMES_IN_USE_RST;
			shift_period_q    <= SHIFT_PERIOD_RST;
			hit_cost_q        <= HIT_COST_RST;
			miss_extra_cost_q <= MISS_EXTRA_COST_RST;
			age_bits_q        <= AGE_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAMES_IN_USE:   frames_in_use_q   <= cfg_data[3:0];
				CFG_SHIFT_PERIOD:    shift_period_q    <= cfg_data;
				CFG_HIT_COST:        hit_cost_q        <= cfg_data[7:0];
				CFG_MISS_EXTRA_COST: miss_extra_cost_q <= cfg_data[7:0];
				CFG_AGE_BITS:        age_bits_q        <= cfg_data[3:0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	// clamp frame cap to 1..FRAMES and age width to 1..AGE_WIDTH
	logic [CW-1:0]        cap;
	logic [5:0]           age_top;
	logic [AGE_WIDTH-1:0] age_mark;

	always_comb begin
		if (frames_in_use_q == '0) begin
			cap = CW'(1);
		end else if (32'(frames_in_use_q) > FRAMES) begin
			cap = CW'(FRAMES);
		end else begin
			cap = CW'(frames_in_use_q);
		end
		if (age_bits_q == '0) begin
			age_top = 6'd0;
		end else if (32'(age_bits_q) > AGE_WIDTH) begin
			age_top = 6'(AGE_WIDTH - 1);
		end else begin
			age_top = 6'(age_bits_q) - 6'd1;
		end
		age_mark = AGE_WIDTH'(1) << age_top;
	end

	// ------------------------------------------------------------------
	// Page number reduction: constant table, page mod PAGE_COUNT
	// ------------------------------------------------------------------
	logic [PW-1:0] page_lut [256];

	for (genvar g = 0; g < 256; g++) begin : g_lut
		assign page_lut[g] = PW'(g % PAGE_COUNT);
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	state_t state_q, state_d;
	logic   accept;
	logic   clr_last;
	logic   pm_hit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = pm_hit ? ST_IDLE : ST_EVICT;
			end
			ST_EVICT: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Memories: page map {valid, frame} and frame-to-page map
	// ------------------------------------------------------------------
	logic          pm_we;
	logic [PW-1:0] pm_waddr;
	logic [FW:0]   pm_wdata;
	logic [FW:0]   pm_rdata;
	logic [PW-1:0] fpm_rdata;
	logic [FW-1:0] victim;

	logic [PW-1:0]   clr_addr_q;
	logic [PW-1:0]   page_q;
	logic            run_end_q;
	logic [FW-1:0]   frame_q;
	logic            evict_q;

	assign clr_last = (clr_addr_q == PW'(PAGE_COUNT - 1));

	alru_ram #(
		.WIDTH (FW + 1),
		.DEPTH (PAGE_COUNT)
	) u_page_map (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (pm_wdata),
		.re    (accept),
		.raddr (page_lut[item.page_number]),
		.rdata (pm_rdata)
	);

	// victim's old page is read in the look cycle, new page written on evict
	alru_ram #(
		.WIDTH (PW),
		.DEPTH (FRAMES)
	) u_frame_map (
		.clk   (clk),
		.we    (state_q == ST_EVICT),
		.waddr (frame_q),
		.wdata (page_q),
		.re    (state_q == ST_LOOK),
		.raddr (victim),
		.rdata (fpm_rdata)
	);

	// ------------------------------------------------------------------
	// Look cycle: hit/miss, frame choice, time cost
	// ------------------------------------------------------------------
	logic [AGE_WIDTH-1:0] age_q [FRAMES];
	logic [CW-1:0]        filled_q;
	logic [31:0]          elapsed_q;
	logic [31:0]          fault_q;

	logic          use_free;
	logic [FW-1:0] look_frame;
	logic          look_evict;
	logic [8:0]    cost;
	logic [32:0]   el_sum;
	logic [31:0]   el_next;
	logic [32:0]   fault_sum;

	alru_victim #(
		.FRAMES    (FRAMES),
		.AGE_WIDTH (AGE_WIDTH)
	) u_victim (
		.age    (age_q),
		.cap    (cap),
		.victim (victim)
	);

	assign pm_hit     = pm_rdata[FW];
	assign use_free   = (filled_q < cap);
	assign look_evict = !pm_hit && !use_free;

	always_comb begin
		if (pm_hit) begin
			look_frame = pm_rdata[FW-1:0];
		end else if (use_free) begin
			look_frame = FW'(filled_q);
		end else begin
			look_frame = victim;
		end
		cost      = pm_hit ? {1'b0, hit_cost_q}
		                   : ({1'b0, hit_cost_q} + {1'b0, miss_extra_cost_q});
		el_sum    = {1'b0, elapsed_q} + 33'(cost);
		el_next   = el_sum[32] ? '1 : el_sum[31:0];
		fault_sum = {1'b0, fault_q} + 33'd1;
	end

	// page map write port: clear sweep, new mapping on miss, invalidate on evict
	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = clr_addr_q;
		pm_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				pm_we = 1'b1;
			end
			ST_LOOK: begin
				pm_we    = !pm_hit;
				pm_waddr = page_q;
				pm_wdata = {1'b1, look_frame};
			end
			ST_EVICT: begin
				pm_we    = evict_q;
				pm_waddr = fpm_rdata;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			filled_q   <= '0;
			elapsed_q  <= '0;
			fault_q    <= '0;
			done       <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			done <= ((state_q == ST_LOOK) && pm_hit) || (state_q == ST_EVICT);
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + PW'(1);
			end
			// aging shift comes before the lookup; do it on the accept edge
			if (accept && (elapsed_q >= 32'(shift_period_q))) begin
				elapsed_q <= elapsed_q - 32'(shift_period_q);
				for (int i = 0; i < FRAMES; i++) begin
					age_q[i] <= age_q[i] >> 1;
				end
			end
			if (state_q == ST_LOOK) begin
				elapsed_q <= el_next;
				for (int i = 0; i < FRAMES; i++) begin
					if (look_frame == FW'(i)) begin
						age_q[i] <= age_q[i] | age_mark;
					end
				end
				if (!pm_hit) begin
					fault_q <= fault_sum[32] ? '1 : fault_sum[31:0];
					if (use_free) begin
						filled_q <= filled_q + CW'(1);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q    <= page_lut[item.page_number];
			run_end_q <= item.run_end;
		end
		if (state_q == ST_LOOK) begin
			frame_q <= look_frame;
			evict_q <= look_evict;
			result.page_fault   <= 1'b0;
			result.frame        <= 3'(look_frame);
			result.evicted      <= 1'b0;
			result.evicted_page <= '0;
			result.fault_total  <= fault_q;
			result.last_result  <= run_end_q;
		end
		if (state_q == ST_EVICT) begin
			result.page_fault   <= 1'b1;
			result.frame        <= 3'(frame_q);
			result.evicted      <= evict_q;
			result.evicted_page <= evict_q ? 8'(fpm_rdata) : 8'd0;
			result.fault_total  <= fault_q;
			result.last_result  <= run_end_q;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_LOOK || $past(state_q) == ST_EVICT))
		else $error("result strobe without a finished lookup");

	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.evicted |-> result.page_fault)
		else $error("eviction reported on a hit");

	a_hit_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) && pm_hit |-> (CW'(pm_rdata[FW-1:0]) < filled_q))
		else $error("hit maps to a frame never filled");

	a_evict_other: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) && evict_q |-> (fpm_rdata != page_q))
		else $error("evicting the page being loaded");

	a_filled_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) && !pm_hit && use_free |=> (filled_q <= CW'(FRAMES)))
		else $error("fill count past frame total");

endmodule
